FILE: rtl/core/mrm_pkg.sv
// Shared types, codes and the CRC-16 byte step for the Modbus RTU read master.
// No dependencies; mrm_job_fifo, mrm_front, mrm_back and the top module import this package.
package mrm_pkg;

	// input commands
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_REQ_BYTE = 2'd0;
	localparam logic [1:0] KIND_WORD     = 2'd1;
	localparam logic [1:0] KIND_STATUS   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_COUNT = 2'd1;
	localparam logic [1:0] ST_CRC_ERR   = 2'd2;
	localparam logic [1:0] ST_TIMEOUT   = 2'd3;

	// configuration register indexes
	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_TIMEOUT_TICKS  = 1'b1;

	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [7:0]  DEV_ADDR_RESET    = 8'd1;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd100;

	typedef enum logic [1:0] {
		JOB_REQ,
		JOB_WORDS,
		JOB_STATUS
	} job_kind_t;

	// work handed from the front to the back through the job queue
	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] addr;
		logic [6:0]  cnt;
		logic [1:0]  status;
	} job_t;

	// CRC-16/MODBUS over one byte, reflected form
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/mrm_if.sv
// Valid/ready channel interfaces of the Modbus RTU read master:
// command items, result items and configuration writes. No dependencies.
interface mrm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] start_addr;
	logic [6:0]  reg_count;
	logic [7:0]  rx_byte;

	modport source (output valid, cmd, start_addr, reg_count, rx_byte, input ready);
	modport sink (input valid, cmd, start_addr, reg_count, rx_byte, output ready);
endinterface

interface mrm_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] value;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, kind, value, status, last, input ready);
	modport sink (input valid, kind, value, status, last, output ready);
endinterface

interface mrm_cfg_if;
	logic        valid;
	logic        ready;
	logic        addr;
	logic [15:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

FILE: rtl/core/mrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/mrm_job_fifo.sv
// Two-entry job queue between the front and back of the read master.
// Depends on mrm_pkg (job_t).
module mrm_job_fifo import mrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	localparam int DEPTH = 2;

	job_t                     mem_q [DEPTH];
	logic                     wr_ptr_q;
	logic                     rd_ptr_q;
	logic [$clog2(DEPTH):0]   count_q;
	logic                     do_push;
	logic                     do_pop;

	assign full    = (count_q == ($clog2(DEPTH)+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + ($clog2(DEPTH)+1)'(1);
				2'b01:   count_q <= count_q - ($clog2(DEPTH)+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/mrm_front.sv
// Front of the read master: accepts command items, tracks the pending read,
// runs the response CRC, stores register words and queues jobs. Uses mrm_pkg.
module mrm_front import mrm_pkg::*; #(
	parameter int MAX_REGS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	mrm_item_if.sink                                    item,
	input  logic [15:0]                                 timeout_ticks,
	input  logic                                        job_full,
	output logic                                        job_push,
	output job_t                                        job,
	input  logic                                        words_done,
	output logic                                        words_busy,
	output logic                                        ram_we,
	output logic [(MAX_REGS > 1 ? $clog2(MAX_REGS) : 1)-1:0] ram_addr,
	output logic [15:0]                                 ram_data
);

	localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

	logic        pending_q;
	logic [7:0]  expected_q;
	logic [7:0]  received_q;
	logic [6:0]  pending_count_q;
	logic [15:0] crc_q;
	logic [15:0] last_two_q;
	logic [15:0] tick_q;
	logic        busy_q;
	logic [7:0]  hi_q;

	logic        accept;
	logic        bad_count;
	logic [7:0]  data_idx;
	logic        in_data;
	logic        crc_en;
	logic        frame_done;
	logic [15:0] crc_got;
	logic [15:0] tick_next;
	logic        timed_out;

	assign item.ready = !job_full && !busy_q;
	assign accept     = item.valid && item.ready;
	assign words_busy = busy_q;

	assign bad_count  = (item.reg_count == 7'd0) || (item.reg_count > 7'(MAX_REGS));
	assign data_idx   = received_q - 8'd3;
	assign in_data    = (received_q >= 8'd3) &&
	                    (received_q < 8'd3 + {pending_count_q, 1'b0});
	assign crc_en     = (received_q + 8'd2) < expected_q;
	assign frame_done = (received_q + 8'd1) >= expected_q;
	// transmitted CRC is low byte first
	assign crc_got    = {item.rx_byte, last_two_q[7:0]};
	assign tick_next  = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
	assign timed_out  = tick_next >= timeout_ticks;

	assign ram_addr = data_idx[AW:1];
	assign ram_data = {hi_q, item.rx_byte};

	always_comb begin
		job_push   = 1'b0;
		job.kind   = JOB_STATUS;
		job.addr   = item.start_addr;
		job.cnt    = item.reg_count;
		job.status = ST_OK;
		ram_we     = 1'b0;
		if (accept) begin
			case (item.cmd)
				CMD_START: begin
					job_push = 1'b1;
					if (bad_count) begin
						job.status = ST_BAD_COUNT;
					end else begin
						job.kind = JOB_REQ;
					end
				end
				CMD_BYTE: begin
					if (pending_q) begin
						ram_we = in_data && data_idx[0];
						if (frame_done) begin
							job_push = 1'b1;
							job.cnt  = pending_count_q;
							if (crc_got == crc_q) begin
								job.kind = JOB_WORDS;
							end else begin
								job.status = ST_CRC_ERR;
							end
						end
					end
				end
				CMD_TICK: begin
					if (pending_q && timed_out) begin
						job_push   = 1'b1;
						job.status = ST_TIMEOUT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.cmd == CMD_BYTE && pending_q && in_data && !data_idx[0]) begin
			hi_q <= item.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q       <= 1'b0;
			expected_q      <= '0;
			received_q      <= '0;
			pending_count_q <= '0;
			crc_q           <= CRC_INIT;
			last_two_q      <= '0;
			tick_q          <= '0;
			busy_q          <= 1'b0;
		end else begin
			if (job_push && job.kind == JOB_WORDS) begin
				busy_q <= 1'b1;
			end else if (words_done) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				case (item.cmd)
					CMD_START: begin
						if (!bad_count) begin
							pending_q       <= 1'b1;
							pending_count_q <= item.reg_count;
							expected_q      <= 8'd5 + {item.reg_count, 1'b0};
							received_q      <= '0;
							crc_q           <= CRC_INIT;
							last_two_q      <= '0;
							tick_q          <= '0;
						end
					end
					CMD_BYTE: begin
						if (pending_q) begin
							if (crc_en) begin
								crc_q <= crc_byte(crc_q, item.rx_byte);
							end
							last_two_q <= {last_two_q[7:0], item.rx_byte};
							received_q <= received_q + 8'd1;
							if (frame_done) begin
								pending_q <= 1'b0;
							end
						end
					end
					CMD_TICK: begin
						if (pending_q) begin
							tick_q <= tick_next;
							if (timed_out) begin
								pending_q <= 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/core/mrm_back.sv
// Back of the read master: pops jobs and drives the result register with
// request bytes (CRC built on the fly), stored words or a status. Uses mrm_pkg.
module mrm_back import mrm_pkg::*; #(
	parameter int MAX_REGS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        job_valid,
	input  job_t                                        job,
	output logic                                        job_pop,
	input  logic [7:0]                                  device_address,
	output logic [(MAX_REGS > 1 ? $clog2(MAX_REGS) : 1)-1:0] rd_addr,
	input  logic [15:0]                                 rd_data,
	output logic                                        words_done,
	mrm_result_if.source                                result
);

	localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

	typedef enum logic [2:0] {
		B_IDLE,
		B_REQ,
		B_WRD,
		B_WLD,
		B_STAT
	} state_t;

	state_t      state_q;
	job_t        job_q;
	logic [6:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [15:0] value_q;
	logic [1:0]  status_q;
	logic        last_q;

	logic        can_load;
	logic [7:0]  req_byte;
	logic        last_word;

	assign can_load   = !out_valid_q || result.ready;
	assign job_pop    = (state_q == B_IDLE) && job_valid;
	assign rd_addr    = idx_q[AW-1:0];
	assign last_word  = (idx_q == job_q.cnt - 7'd1);
	assign words_done = (state_q == B_WLD) && can_load && last_word;

	assign result.valid  = out_valid_q;
	assign result.kind   = kind_q;
	assign result.value  = value_q;
	assign result.status = status_q;
	assign result.last   = last_q;

	always_comb begin
		case (idx_q[2:0])
			3'd0:    req_byte = device_address;
			3'd1:    req_byte = FUNC_READ_HOLDING;
			3'd2:    req_byte = job_q.addr[15:8];
			3'd3:    req_byte = job_q.addr[7:0];
			3'd4:    req_byte = 8'h00;
			3'd5:    req_byte = {1'b0, job_q.cnt};
			3'd6:    req_byte = crc_q[7:0];
			default: req_byte = crc_q[15:8];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			job_q       <= '0;
			idx_q       <= '0;
			crc_q       <= CRC_INIT;
			kind_q      <= KIND_STATUS;
			value_q     <= '0;
			status_q    <= ST_OK;
			last_q      <= 1'b0;
		end else begin
			// drop the result once transferred; a new load below overrides
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						job_q <= job;
						idx_q <= '0;
						crc_q <= CRC_INIT;
						case (job.kind)
							JOB_REQ:   state_q <= B_REQ;
							JOB_WORDS: state_q <= B_WRD;
							default:   state_q <= B_STAT;
						endcase
					end
				end
				B_REQ: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_REQ_BYTE;
						value_q     <= {8'h00, req_byte};
						status_q    <= ST_OK;
						last_q      <= (idx_q == 7'd7);
						if (idx_q < 7'd6) begin
							crc_q <= crc_byte(crc_q, req_byte);
						end
						if (idx_q == 7'd7) begin
							state_q <= B_IDLE;
						end else begin
							idx_q <= idx_q + 7'd1;
						end
					end
				end
				B_WRD: begin
					// wait here for the registered read
					state_q <= B_WLD;
				end
				B_WLD: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_WORD;
						value_q     <= rd_data;
						status_q    <= ST_OK;
						last_q      <= last_word;
						if (last_word) begin
							state_q <= B_IDLE;
						end else begin
							idx_q   <= idx_q + 7'd1;
							state_q <= B_WRD;
						end
					end
				end
				B_STAT: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_STATUS;
						value_q     <= '0;
						status_q    <= job_q.status;
						last_q      <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/modbus_rtu_read_master.sv
// Modbus RTU read-holding-registers master: configuration registers, front,
// job queue, word store and back. Uses mrm_pkg, mrm_if and the rtl/core modules.
//
// Channels: item (cmd 0 start read, 1 received line byte, 2 timer tick),
// result (request bytes, register words or a status, last on the final one
// per item) and cfg (register 0 device address, register 1 timeout ticks).
// An item is transferred when valid and ready are high at a clock edge; cfg
// is always ready. A start gives eight request byte results, one per cycle
// unless the result stalls, after the job queue and the back's idle state, or
// a bad count status. A frame's last byte yields words (one store read and one
// load each) or one CRC error status. Items are taken one per cycle while the
// two-entry job queue has room; no item is taken while stored words are still
// being read out. A stalled result holds in the output register, the queue
// fills and item ready drops. Reset sets the device address to 1 and the
// timeout to 100 ticks and leaves no read pending; the word store is not
// cleared, since every word read out was written by the current response.
module modbus_rtu_read_master import mrm_pkg::*; #(
	parameter int MAX_REGS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	mrm_item_if.sink      item,
	mrm_result_if.source  result,
	mrm_cfg_if.sink       cfg
);

	localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

	logic [7:0]    device_address_q;
	logic [15:0]   timeout_ticks_q;

	logic          job_push;
	job_t          push_job;
	logic          job_pop;
	job_t          pop_job;
	logic          job_full;
	logic          job_empty;
	logic          words_done;
	logic          words_busy;
	logic          ram_we;
	logic [AW-1:0] ram_wr_addr;
	logic [15:0]   ram_wr_data;
	logic [AW-1:0] ram_rd_addr;
	logic [15:0]   ram_rd_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= DEV_ADDR_RESET;
			timeout_ticks_q  <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_DEVICE_ADDRESS: device_address_q <= cfg.data[7:0];
				REG_TIMEOUT_TICKS:  timeout_ticks_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	mrm_front #(.MAX_REGS(MAX_REGS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.timeout_ticks (timeout_ticks_q),
		.job_full      (job_full),
		.job_push      (job_push),
		.job           (push_job),
		.words_done    (words_done),
		.words_busy    (words_busy),
		.ram_we        (ram_we),
		.ram_addr      (ram_wr_addr),
		.ram_data      (ram_wr_data)
	);

	mrm_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.pop_job  (pop_job),
		.full     (job_full),
		.empty    (job_empty)
	);

	mrm_ram #(.WIDTH(16), .DEPTH(MAX_REGS)) u_word_store (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	mrm_back #(.MAX_REGS(MAX_REGS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (!job_empty),
		.job            (pop_job),
		.job_pop        (job_pop),
		.device_address (device_address_q),
		.rd_addr        (ram_rd_addr),
		.rd_data        (ram_rd_data),
		.words_done     (words_done),
		.result         (result)
	);

	a_store_quiet_during_readout: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !words_busy)
		else $error("word store written while words are read out");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == KIND_STATUS |-> result.last && result.value == 16'd0)
		else $error("status result not last or carries a value");

	a_word_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.kind == KIND_WORD || result.kind == KIND_REQ_BYTE)
		|-> result.status == ST_OK)
		else $error("data result carries a nonzero status");

	a_busy_clears: assert property (@(posedge clk) disable iff (!arst_n)
		words_done |=> !words_busy)
		else $error("readout busy not cleared after last word");

endmodule
